// ----- rtl/lrh_pkg.sv -----
package lrh_pkg;

  localparam int PIXEL_W = 24;
  localparam int CFG_W   = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_TOTAL_PIXELS = 2'd0;
  localparam logic [1:0] REG_WIDE_PIXELS  = 2'd1;

  // Kind of run header that goes ahead of a pixel.
  localparam logic [1:0] HDR_NONE  = 2'd0;
  localparam logic [1:0] HDR_SHORT = 2'd1;
  localparam logic [1:0] HDR_LONG  = 2'd2;

  localparam logic [7:0] LONG_MARK = 8'h7f;

  // Command queue between the classifier and the byte serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic               overrun;
    logic               wide;
    logic [1:0]         hdr_kind;
    logic [15:0]        hdr_val;
    logic [PIXEL_W-1:0] pixel;
  } lrh_cmd_t;

endpackage

// ----- rtl/literal_run_header_encoder.sv -----
// Channel   Ports                                         Direction
// input     in_valid, in_stall, in_pixel                  pixels in, one beat each
// output    out_valid, out_stall, out_byte/last/overrun   encoded bytes, one beat each
// config    cfg_we, cfg_index, cfg_data                   register writes, no wait
//
// The classifier takes one pixel per cycle, unless the queue is full, into a
// four-entry command queue. The serializer sends one byte per cycle unless
// out_stall holds it, so a pixel costs 1 to 6 output bytes: 3 for a three-byte
// pixel, 1 for a one-byte pixel, plus 1 or 3 for a header. With the queue empty,
// a pixel's first byte passes the queue entry, then the output register.
// Reset is synchronous: total_pixels reads as 0 and wide_pixels as 1.
// in_stall rises only when the queue is full; out_stall holds the output register.
module literal_run_header_encoder
  import lrh_pkg::*;
#(
  parameter int MAX_WINDOW = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIXEL_W-1:0] in_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_overrun
);

  logic     q_full;
  logic     push;
  lrh_cmd_t push_cmd;
  logic     pop;
  logic     head_valid;
  lrh_cmd_t head_cmd;

  lrh_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lrh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  lrh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_overrun(out_overrun)
  );

endmodule

// ----- rtl/lrh_front.sv -----
module lrh_front
  import lrh_pkg::*;
#(
  parameter int MAX_WINDOW = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIXEL_W-1:0] in_pixel,
  input  logic               q_full,
  output logic               push,
  output lrh_cmd_t           push_cmd
);

  localparam int WinW = $clog2(MAX_WINDOW + 1);
  localparam logic [PIXEL_W-1:0] MaxWin = PIXEL_W'(MAX_WINDOW);

  logic [PIXEL_W-1:0] pixels_left_r, pixels_left_nxt;
  logic [WinW-1:0]    window_left_r, window_left_nxt;
  logic               first_done_r, first_done_nxt;
  logic               wide_r, wide_nxt;

  logic [PIXEL_W-1:0] win_full;
  logic [WinW-1:0]    win;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  assign win_full = (pixels_left_r > MaxWin) ? MaxWin : pixels_left_r;
  assign win      = win_full[WinW-1:0];

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    window_left_nxt = window_left_r;
    first_done_nxt  = first_done_r;
    wide_nxt        = wide_r;

    push_cmd.overrun  = (pixels_left_r == '0);
    push_cmd.wide     = wide_r;
    push_cmd.hdr_kind = HDR_NONE;
    push_cmd.hdr_val  = '0;
    push_cmd.pixel    = in_pixel;

    // A header is due only once the first pixel is out and the window is used up.
    if (pixels_left_r != '0 && first_done_r && window_left_r == '0) begin
      if (win >= WinW'(128)) begin
        push_cmd.hdr_kind = HDR_LONG;
        push_cmd.hdr_val  = 16'(win - WinW'(128));
      end else begin
        push_cmd.hdr_kind = HDR_SHORT;
        push_cmd.hdr_val  = 16'(win - WinW'(1));
      end
    end

    if (accept && pixels_left_r != '0) begin
      pixels_left_nxt = pixels_left_r - PIXEL_W'(1);
      if (!first_done_r) begin
        first_done_nxt = 1'b1;
      end else if (window_left_r == '0) begin
        window_left_nxt = win - WinW'(1);
      end else begin
        window_left_nxt = window_left_r - WinW'(1);
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_PIXELS: begin
          pixels_left_nxt = cfg_data[PIXEL_W-1:0];
          window_left_nxt = '0;
          first_done_nxt  = 1'b0;
        end
        REG_WIDE_PIXELS: begin
          wide_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      window_left_r <= '0;
      first_done_r  <= 1'b0;
      wide_r        <= 1'b1;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      window_left_r <= window_left_nxt;
      first_done_r  <= first_done_nxt;
      wide_r        <= wide_nxt;
    end
  end

endmodule

// ----- rtl/lrh_fifo.sv -----
module lrh_fifo
  import lrh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lrh_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output lrh_cmd_t head_cmd
);

  lrh_cmd_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/lrh_back.sv -----
module lrh_back
  import lrh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  lrh_cmd_t head_cmd,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [7:0] out_byte,
  output logic     out_last,
  output logic     out_overrun
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_overrun_r;

  logic [2:0] hlen;
  logic [2:0] nbytes;
  logic [1:0] pidx;
  logic [7:0] sel_byte;
  logic       load;
  logic       step;
  logic       is_last;

  always_comb begin
    case (head_cmd.hdr_kind)
      HDR_SHORT: hlen = 3'd1;
      HDR_LONG:  hlen = 3'd3;
      default:   hlen = 3'd0;
    endcase
    if (head_cmd.overrun) begin
      nbytes = 3'd1;
    end else begin
      nbytes = hlen + (head_cmd.wide ? 3'd3 : 3'd1);
    end

    pidx = 2'(idx_r - hlen);
    if (head_cmd.overrun) begin
      sel_byte = 8'h00;
    end else if (idx_r < hlen) begin
      case (idx_r)
        3'd0:    sel_byte = (head_cmd.hdr_kind == HDR_LONG) ? LONG_MARK
                                                            : head_cmd.hdr_val[7:0];
        3'd1:    sel_byte = head_cmd.hdr_val[7:0];
        default: sel_byte = head_cmd.hdr_val[15:8];
      endcase
    end else begin
      case (pidx)
        2'd0:    sel_byte = head_cmd.pixel[7:0];
        2'd1:    sel_byte = head_cmd.pixel[15:8];
        default: sel_byte = head_cmd.pixel[23:16];
      endcase
    end
  end

  // The output register takes a new beat when it is empty or being drained.
  assign load    = !out_valid_r || !out_stall;
  assign step    = head_valid && load;
  assign is_last = (idx_r == nbytes - 3'd1);
  assign pop     = step && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (step) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r    <= sel_byte;
      out_last_r    <= is_last;
      out_overrun_r <= head_cmd.overrun;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;
  assign out_overrun = out_overrun_r;

`ifndef SYNTHESIS
  a_overrun_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_overrun_r |-> out_last_r)
    else $error("overrun beat not marked last");

  a_mid_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> head_valid && !head_cmd.overrun)
    else $error("queue head lost in the middle of an entry");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'd5)
    else $error("byte index beyond six beats");
`endif

endmodule

// ----- dv/literal_run_header_encoder_tb.sv -----
`timescale 1ns / 1ps

module literal_run_header_encoder_tb;
  import lrh_pkg::*;

  localparam logic [23:0] WINDOW_MAX = 24'd65535;
  localparam logic [23:0] LONG_MIN   = 24'd128;
  localparam logic [1:0]  REG_SPARE_2 = 2'd2;
  localparam logic [1:0]  REG_SPARE_3 = 2'd3;
  localparam int RAND_ITEMS    = 470;
  localparam int CALM_TAIL     = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PLAN_LEN      = 31;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovr;
  } enc_byte_t;

  typedef enum logic { ROW_CFG, ROW_PIX } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [23:0] value;
    logic [1:0]  n_fixed;
    logic [23:0] fixed_bytes;
    logic        fixed_ovr;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [PIXEL_W-1:0] in_pixel;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last;
  logic               out_overrun;

  // Mirror of the encoder state.
  logic        wide_mode;
  logic [23:0] px_left;
  logic [15:0] win_left;
  logic        raw_sent;

  enc_byte_t enc_q[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  int        stall_run = 0;
  row_t      plan [PLAN_LEN];

  literal_run_header_encoder #(
    .MAX_WINDOW(WINDOW_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_overrun(out_overrun)
  );

  always #6 clk = ~clk;

  function automatic void encode_pixel(input logic [23:0] px, ref enc_byte_t run[$]);
    logic [23:0] w;
    logic [23:0] d;
    if (px_left == 24'd0) begin
      run.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    if (!raw_sent) begin
      raw_sent = 1'b1;
    end else begin
      if (win_left == 16'd0) begin
        w = (px_left > WINDOW_MAX) ? WINDOW_MAX : px_left;
        if (w >= LONG_MIN) begin
          d = w - LONG_MIN;
          run.push_back('{LONG_MARK, 1'b0, 1'b0});
          run.push_back('{d[7:0], 1'b0, 1'b0});
          run.push_back('{d[15:8], 1'b0, 1'b0});
        end else begin
          d = w - 24'd1;
          run.push_back('{d[7:0], 1'b0, 1'b0});
        end
        win_left = w[15:0];
      end
      win_left = win_left - 16'd1;
    end
    run.push_back('{px[7:0], 1'b0, 1'b0});
    if (wide_mode) begin
      run.push_back('{px[15:8], 1'b0, 1'b0});
      run.push_back('{px[23:16], 1'b0, 1'b0});
    end
    px_left = px_left - 24'd1;
    run[run.size()-1].last = 1'b1;
  endfunction

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TOTAL_PIXELS: begin
        px_left   = value;
        win_left  = 16'd0;
        raw_sent  = 1'b0;
      end
      REG_WIDE_PIXELS: wide_mode = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the input side off until every expected byte has come back.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (enc_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A nonzero n_fixed replaces the predicted bytes with typed-in ones.
  task automatic send_pixel(input logic [23:0] px, input logic [1:0] n_fixed,
                            input logic [23:0] fixed_bytes, input logic fixed_ovr);
    enc_byte_t run[$];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_pixel(px, run);
    if (n_fixed != 2'd0) begin
      run.delete();
      for (int i = 0; i < int'(n_fixed); i++) begin
        run.push_back('{fixed_bytes[8*i +: 8], i == int'(n_fixed) - 1, fixed_ovr});
      end
    end
    foreach (run[i]) enc_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_run <= 0;
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_run <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    enc_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (enc_q.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %0b overrun %0b",
                             out_byte, out_last, out_overrun));
      end else begin
        want = enc_q.pop_front();
        if (out_byte !== want.data || out_last !== want.last || out_overrun !== want.ovr) begin
          flag_error($sformatf("expected byte %02h last %0b overrun %0b, got %02h %0b %0b",
                               want.data, want.last, want.ovr,
                               out_byte, out_last, out_overrun));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** literal_run_header_encoder: FAILED **");
    $finish;
  end

  initial begin
    int rand_sent;
    int total;
    int n_pix;
    int split;
    rand_sent = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_TOTAL_PIXELS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    wide_mode = 1'b1;
    px_left   = 24'd0;
    win_left  = 16'd0;
    raw_sent  = 1'b0;

    plan = '{
      // Total is zero out of reset, so the first pixel overruns.
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hABCDEF, 2'd1, 24'h000000, 1'b1},
      '{ROW_CFG, REG_WIDE_PIXELS,  24'hFFFFFF, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd3,      2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h123456, 2'd3, 24'h123456, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h000000, 2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hFFFFFF, 2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h5A5A5A, 2'd1, 24'h000000, 1'b1},
      '{ROW_CFG, REG_WIDE_PIXELS,  24'hFFFFFE, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd129,    2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hFFFF00, 2'd1, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h0000FF, 2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h800001, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd128,    2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h000011, 2'd1, 24'h000011, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h000022, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_SPARE_2,      24'hFFFFFF, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_SPARE_3,      24'h000000, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd2,      2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h0000AA, 2'd1, 24'h0000AA, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h0000BB, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'hFFFFFF, 2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h000000, 2'd1, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hFFFFFF, 2'd0, 24'h000000, 1'b0},
      // Width change in the middle of a window keeps the run going.
      '{ROW_CFG, REG_WIDE_PIXELS,  24'd1,      2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h0F0F0F, 2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hF0F0F0, 2'd0, 24'h000000, 1'b0},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd1,      2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'hC3C3C3, 2'd3, 24'hC3C3C3, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h3C3C3C, 2'd1, 24'h000000, 1'b1},
      '{ROW_CFG, REG_TOTAL_PIXELS, 24'd0,      2'd0, 24'h000000, 1'b0},
      '{ROW_PIX, REG_TOTAL_PIXELS, 24'h000000, 2'd1, 24'h000000, 1'b1}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_pixel(plan[i].value, plan[i].n_fixed, plan[i].fixed_bytes, plan[i].fixed_ovr);
      end
    end

    // Random images, mostly small, some cut short and some run past the end.
    while (rand_sent < RAND_ITEMS) begin
      idle_on = (rand_sent < RAND_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0: total = 0;
        1: total = 1;
        2: total = 2;
        3: total = $urandom_range(127, 130);
        4: total = $urandom_range(131, 260);
        default: total = $urandom_range(3, 24);
      endcase
      settle_idle();
      if ($urandom_range(0, 2) == 0) write_reg(REG_WIDE_PIXELS, 24'($urandom()));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, 24'($urandom()));
      end
      write_reg(REG_TOTAL_PIXELS, 24'(total));
      if ($urandom_range(0, 5) == 0) begin
        n_pix = $urandom_range(0, total);
      end else begin
        n_pix = total + $urandom_range(0, 2);
      end
      if (n_pix > RAND_ITEMS - rand_sent) n_pix = RAND_ITEMS - rand_sent;
      split = 0;
      if (n_pix > 1 && $urandom_range(0, 3) == 0) split = $urandom_range(1, n_pix - 1);
      for (int k = 0; k < n_pix; k++) begin
        if (split != 0 && k == split) begin
          settle_idle();
          write_reg(REG_WIDE_PIXELS, 24'($urandom()));
        end
        send_pixel(rand_pixel(), 2'd0, 24'h000000, 1'b0);
      end
      rand_sent += n_pix;
    end

    idle_on = 1'b0;
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && enc_q.size() == 0) begin
      $display("** literal_run_header_encoder: PASSED **");
    end else begin
      $display("** literal_run_header_encoder: FAILED **");
    end
    $finish;
  end

endmodule
